FILE: design/pnorm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_pkg
// Shared types, widths and codes of the two-pass peak normalizer.
// ----------------------------------------------------------------------------
package pnorm_pkg;

  // gain format: unsigned Q(GAIN_FRAC_BITS)
  localparam int GAIN_FRAC_BITS = 16;

  localparam int SAMPLE_W = 16;
  localparam int TARGET_W = 19;
  localparam int GAIN_W   = 32;
  localparam int CLIP_W   = 24;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1) << GAIN_FRAC_BITS;
  localparam logic [CLIP_W-1:0]   CLIP_MAX     = '1;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // gain divider: numerator is target * 2^15 at most, denominator a peak magnitude
  localparam int DIV_NUM_W = TARGET_W + SAMPLE_W - 1;
  localparam int DIV_DEN_W = SAMPLE_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // scale product: signed sample times unsigned gain
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int RND_W  = PROD_W - GAIN_FRAC_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic REG_TARGET_GAIN = 1'b0;
  localparam logic REG_STEREO      = 1'b1;

  // item op codes
  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_SCALE = 1'b1;

  typedef enum logic [1:0] {
    KIND_SCAN,
    KIND_SCAN_RESTART,
    KIND_SCALE_GAIN,
    KIND_SCALE
  } item_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HIGH_START,
    BK_HIGH_WAIT,
    BK_LOW_START,
    BK_LOW_WAIT,
    BK_GAIN,
    BK_MUL,
    BK_ROUND
  } back_state_t;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [CLIP_W-1:0]          clipped_count;
  } out_item_t;

  typedef struct packed {
    item_kind_t                 kind;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } queue_entry_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_gain;
    logic                stereo;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: design/peak_normalizer_16bit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_normalizer_16bit_unit
// Two-pass peak normalizer for 16-bit mono or stereo samples.
// ----------------------------------------------------------------------------
// scan items: one per cycle through the back end while it is idle, no result
// scale items: one at a time, multiplied, then rounded into the result register
// first scale item of a pass adds up to two 34-step serial divisions for the gain
// a 4-entry queue keeps input transfers going while the back end is busy
// synchronous reset: peaks cleared, target gain 1.0, stereo on, no result pending
module peak_normalizer_16bit_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  pnorm_pkg::in_item_t                 sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output pnorm_pkg::out_item_t                result,
  input  logic                                cfg_wen,
  input  logic                                cfg_index,
  input  logic [pnorm_pkg::TARGET_W-1:0]      cfg_data
);

  pnorm_pkg::cfg_t         cfg;
  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_empty;
  pnorm_pkg::queue_entry_t q_entry;
  pnorm_pkg::queue_entry_t q_head;
  pnorm_pkg::div_req_t     div_req;
  pnorm_pkg::div_rsp_t     div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_gain <= pnorm_pkg::TARGET_RESET;
      cfg.stereo      <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pnorm_pkg::REG_TARGET_GAIN: cfg.target_gain <= cfg_data;
        pnorm_pkg::REG_STEREO:      cfg.stereo      <= cfg_data[0];
        default:                    cfg.stereo      <= cfg.stereo;
      endcase
    end
  end

  pnorm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  pnorm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  pnorm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pnorm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: design/pnorm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module pnorm_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pnorm_pkg::queue_entry_t push_entry,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output pnorm_pkg::queue_entry_t head
);

  pnorm_pkg::queue_entry_t         entries [pnorm_pkg::QUEUE_DEPTH];
  logic [pnorm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [pnorm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [pnorm_pkg::QCNT_W-1:0]    count;

  assign full  = (count == pnorm_pkg::QCNT_W'(pnorm_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/pnorm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_front
// Input side: accepts items and tags each one with what the back must do.
// ----------------------------------------------------------------------------
module pnorm_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  pnorm_pkg::in_item_t     sample,
  input  logic                    q_full,
  output logic                    q_push,
  output pnorm_pkg::queue_entry_t q_entry
);

  // set while the last accepted item was a scale-pass item
  logic last_scale;

  assign sample_stall = q_full;
  assign q_push       = sample_valid && !q_full;

  always_comb begin
    q_entry.left  = sample.sample_left;
    q_entry.right = sample.sample_right;
    unique case (sample.op)
      pnorm_pkg::OP_SCAN: begin
        // a scan after a scale pass opens a new buffer
        q_entry.kind = last_scale ? pnorm_pkg::KIND_SCAN_RESTART : pnorm_pkg::KIND_SCAN;
      end
      pnorm_pkg::OP_SCALE: begin
        // first scale item of a pass computes the gain
        q_entry.kind = last_scale ? pnorm_pkg::KIND_SCALE : pnorm_pkg::KIND_SCALE_GAIN;
      end
      default: begin
        q_entry.kind = pnorm_pkg::KIND_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_scale <= 1'b0;
    end else if (q_push) begin
      last_scale <= (sample.op == pnorm_pkg::OP_SCALE);
    end
  end

endmodule

FILE: design/pnorm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_div
// Restoring divider, one quotient bit per cycle, for the gain computation.
// ----------------------------------------------------------------------------
module pnorm_div (
  input  logic                clk,
  input  logic                rst,
  input  pnorm_pkg::div_req_t req,
  output pnorm_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [pnorm_pkg::DIV_CNT_W-1:0] cnt;
  logic [pnorm_pkg::DIV_NUM_W-1:0] num_q;
  logic [pnorm_pkg::DIV_DEN_W-1:0] den_q;
  logic [pnorm_pkg::DIV_DEN_W-1:0] rem;
  logic [pnorm_pkg::DIV_DEN_W:0]   trial;
  logic                            fits;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  assign trial = {rem, num_q[pnorm_pkg::DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = num_q;

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      num_q <= req.num;
      den_q <= req.den;
      rem   <= '0;
      cnt   <= pnorm_pkg::DIV_CNT_W'(pnorm_pkg::DIV_NUM_W - 1);
    end else if (busy) begin
      rem   <= fits ? pnorm_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                    : trial[pnorm_pkg::DIV_DEN_W-1:0];
      num_q <= {num_q[pnorm_pkg::DIV_NUM_W-2:0], fits};
      cnt   <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

FILE: design/pnorm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_back
// Execution side: peak tracking, gain computation, scaling and result register.
// ----------------------------------------------------------------------------
module pnorm_back (
  input  logic                    clk,
  input  logic                    rst,
  input  pnorm_pkg::cfg_t         cfg,
  input  logic                    q_empty,
  input  pnorm_pkg::queue_entry_t q_head,
  output logic                    q_pop,
  output pnorm_pkg::div_req_t     div_req,
  input  pnorm_pkg::div_rsp_t     div_rsp,
  output logic                    result_valid,
  input  logic                    result_stall,
  output pnorm_pkg::out_item_t    result
);

  localparam logic signed [pnorm_pkg::PROD_W-1:0] RND_HALF =
    pnorm_pkg::PROD_W'(1) << (pnorm_pkg::GAIN_FRAC_BITS - 1);
  localparam logic signed [pnorm_pkg::RND_W-1:0] R_MAX =
    pnorm_pkg::RND_W'(pnorm_pkg::SMP_MAX);
  localparam logic signed [pnorm_pkg::RND_W-1:0] R_MIN =
    pnorm_pkg::RND_W'(pnorm_pkg::SMP_MIN);

  pnorm_pkg::back_state_t state;
  pnorm_pkg::back_state_t state_next;

  logic signed [pnorm_pkg::SAMPLE_W-1:0] peak_high;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] peak_low;
  logic [pnorm_pkg::GAIN_W-1:0]          scale_gain;
  logic [pnorm_pkg::DIV_NUM_W-1:0]       cand_high;
  logic [pnorm_pkg::DIV_NUM_W-1:0]       cand_low;
  logic [pnorm_pkg::CLIP_W-1:0]          clip_total;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] cur_left;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] cur_right;
  logic signed [pnorm_pkg::PROD_W-1:0]   prod_l;
  logic signed [pnorm_pkg::PROD_W-1:0]   prod_r;

  logic                                  restart;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] base_high;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] base_low;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] high_l;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] low_l;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] peak_high_next;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] peak_low_next;

  logic                                  buf_empty;
  logic                                  has_high;
  logic                                  has_low;
  logic [pnorm_pkg::DIV_NUM_W-1:0]       tgt_ext;
  logic [pnorm_pkg::DIV_DEN_W-1:0]       low_mag;
  logic [pnorm_pkg::DIV_NUM_W-1:0]       best;
  logic [pnorm_pkg::GAIN_W-1:0]          scale_gain_next;

  logic signed [pnorm_pkg::PROD_W-1:0]   v_l;
  logic signed [pnorm_pkg::PROD_W-1:0]   v_r;
  logic signed [pnorm_pkg::RND_W-1:0]    r_l;
  logic signed [pnorm_pkg::RND_W-1:0]    r_r;
  logic                                  clip_l;
  logic                                  clip_r;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] o_l;
  logic signed [pnorm_pkg::SAMPLE_W-1:0] o_r;
  logic [pnorm_pkg::CLIP_W:0]            clip_sum;
  logic [pnorm_pkg::CLIP_W-1:0]          clip_total_next;
  logic                                  out_free;

  // ---- peak tracking ----
  assign restart   = (q_head.kind == pnorm_pkg::KIND_SCAN_RESTART);
  assign base_high = restart ? pnorm_pkg::SMP_MIN : peak_high;
  assign base_low  = restart ? pnorm_pkg::SMP_MAX : peak_low;
  assign high_l    = (q_head.left > base_high) ? q_head.left : base_high;
  assign low_l     = (q_head.left < base_low) ? q_head.left : base_low;
  assign peak_high_next = (cfg.stereo && q_head.right > high_l) ? q_head.right : high_l;
  assign peak_low_next  = (cfg.stereo && q_head.right < low_l) ? q_head.right : low_l;

  // ---- gain ----
  assign buf_empty = (peak_high < peak_low);
  assign has_high  = (peak_high > 0);
  assign has_low   = (peak_low != 0) && !buf_empty;
  assign tgt_ext   = pnorm_pkg::DIV_NUM_W'(cfg.target_gain);
  assign low_mag   = peak_low[pnorm_pkg::SAMPLE_W-1]
                   ? pnorm_pkg::DIV_DEN_W'(-peak_low) : pnorm_pkg::DIV_DEN_W'(peak_low);

  always_comb begin
    if (has_high && has_low) begin
      best = (cand_low < cand_high) ? cand_low : cand_high;
    end else if (has_high) begin
      best = cand_high;
    end else begin
      best = cand_low;
    end
    if (!has_high && !has_low) begin
      // all-zero or empty buffer keeps the target
      scale_gain_next = pnorm_pkg::GAIN_W'(cfg.target_gain);
    end else if (best[pnorm_pkg::DIV_NUM_W-1:pnorm_pkg::GAIN_W] != '0) begin
      scale_gain_next = '1;
    end else begin
      scale_gain_next = best[pnorm_pkg::GAIN_W-1:0];
    end
  end

  // ---- round half up and clamp ----
  assign v_l = prod_l + RND_HALF;
  assign v_r = prod_r + RND_HALF;
  assign r_l = pnorm_pkg::RND_W'(v_l >>> pnorm_pkg::GAIN_FRAC_BITS);
  assign r_r = pnorm_pkg::RND_W'(v_r >>> pnorm_pkg::GAIN_FRAC_BITS);
  assign clip_l = (r_l > R_MAX) || (r_l < R_MIN);
  assign clip_r = cfg.stereo && ((r_r > R_MAX) || (r_r < R_MIN));

  always_comb begin
    if (clip_l) begin
      o_l = r_l[pnorm_pkg::RND_W-1] ? pnorm_pkg::SMP_MIN : pnorm_pkg::SMP_MAX;
    end else begin
      o_l = r_l[pnorm_pkg::SAMPLE_W-1:0];
    end
    if (!cfg.stereo) begin
      o_r = '0;
    end else if (clip_r) begin
      o_r = r_r[pnorm_pkg::RND_W-1] ? pnorm_pkg::SMP_MIN : pnorm_pkg::SMP_MAX;
    end else begin
      o_r = r_r[pnorm_pkg::SAMPLE_W-1:0];
    end
  end

  assign clip_sum = {1'b0, clip_total} + (pnorm_pkg::CLIP_W + 1)'(clip_l)
                  + (pnorm_pkg::CLIP_W + 1)'(clip_r);
  assign clip_total_next = (clip_sum > {1'b0, pnorm_pkg::CLIP_MAX})
                         ? pnorm_pkg::CLIP_MAX : clip_sum[pnorm_pkg::CLIP_W-1:0];

  assign out_free = !result_valid || !result_stall;

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      pnorm_pkg::BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            pnorm_pkg::KIND_SCALE_GAIN: state_next = pnorm_pkg::BK_HIGH_START;
            pnorm_pkg::KIND_SCALE:      state_next = pnorm_pkg::BK_MUL;
            default:                    state_next = pnorm_pkg::BK_IDLE;
          endcase
        end
      end
      pnorm_pkg::BK_HIGH_START: begin
        state_next = has_high ? pnorm_pkg::BK_HIGH_WAIT : pnorm_pkg::BK_LOW_START;
      end
      pnorm_pkg::BK_HIGH_WAIT: begin
        if (div_rsp.done) begin
          state_next = pnorm_pkg::BK_LOW_START;
        end
      end
      pnorm_pkg::BK_LOW_START: begin
        state_next = has_low ? pnorm_pkg::BK_LOW_WAIT : pnorm_pkg::BK_GAIN;
      end
      pnorm_pkg::BK_LOW_WAIT: begin
        if (div_rsp.done) begin
          state_next = pnorm_pkg::BK_GAIN;
        end
      end
      pnorm_pkg::BK_GAIN: begin
        state_next = pnorm_pkg::BK_MUL;
      end
      pnorm_pkg::BK_MUL: begin
        state_next = pnorm_pkg::BK_ROUND;
      end
      pnorm_pkg::BK_ROUND: begin
        if (out_free) begin
          state_next = pnorm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = pnorm_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop         = (state == pnorm_pkg::BK_IDLE) && !q_empty;
    div_req.start = 1'b0;
    div_req.num   = tgt_ext << (pnorm_pkg::SAMPLE_W - 1);
    div_req.den   = low_mag;
    unique case (state)
      pnorm_pkg::BK_HIGH_START: begin
        div_req.start = has_high;
        // 32767 * target
        div_req.num   = (tgt_ext << (pnorm_pkg::SAMPLE_W - 1)) - tgt_ext;
        div_req.den   = pnorm_pkg::DIV_DEN_W'(peak_high);
      end
      pnorm_pkg::BK_LOW_START: begin
        div_req.start = has_low;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnorm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_high  <= pnorm_pkg::SMP_MIN;
      peak_low   <= pnorm_pkg::SMP_MAX;
      clip_total <= '0;
    end else if (q_pop && (q_head.kind == pnorm_pkg::KIND_SCAN || restart)) begin
      peak_high <= peak_high_next;
      peak_low  <= peak_low_next;
      if (restart) begin
        clip_total <= '0;
      end
    end else if (state == pnorm_pkg::BK_ROUND && out_free) begin
      clip_total <= clip_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_left  <= q_head.left;
      cur_right <= q_head.right;
    end
    if (div_rsp.done && state == pnorm_pkg::BK_HIGH_WAIT) begin
      cand_high <= div_rsp.quot;
    end
    if (div_rsp.done && state == pnorm_pkg::BK_LOW_WAIT) begin
      cand_low <= div_rsp.quot;
    end
    if (state == pnorm_pkg::BK_GAIN) begin
      scale_gain <= scale_gain_next;
    end
    if (state == pnorm_pkg::BK_MUL) begin
      prod_l <= pnorm_pkg::PROD_W'(cur_left) * pnorm_pkg::PROD_W'($signed({1'b0, scale_gain}));
      prod_r <= pnorm_pkg::PROD_W'(cur_right) * pnorm_pkg::PROD_W'($signed({1'b0, scale_gain}));
    end
    if (state == pnorm_pkg::BK_ROUND && out_free) begin
      result.out_left      <= o_l;
      result.out_right     <= o_r;
      result.clipped_count <= clip_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == pnorm_pkg::BK_ROUND && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == pnorm_pkg::BK_IDLE) && !q_empty)
    else $error("queue popped outside idle");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == pnorm_pkg::BK_HIGH_WAIT) || (state == pnorm_pkg::BK_LOW_WAIT))
    else $error("divider finished while not awaited");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_clip_mono: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && restart) |=> clip_total >= $past(clip_total))
    else $error("clip count dropped without a new buffer");

  a_mono_right: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !cfg.stereo) |-> (result.out_right == '0))
    else $error("mono result carries a right sample");
`endif

endmodule
